// File: rtl/core/hptr_pkg.sv
// Shared widths, entry layout and helper functions for the hashed page table refill block.
package hptr_pkg;

   localparam int VADDR_W = 32;
   localparam int VSID_W = 24;
   localparam int PFN_W = 20;
   localparam int SLOT_W = 13;
   localparam int PROT_W = 2;
   localparam int PAGE_W = 16;
   localparam int API_W = 6;
   localparam int PAGE_SHIFT = 12;
   localparam int API_SHIFT = 22;
   localparam int WAY_W = 3;
   localparam int WAYS = 8;
   localparam logic [PROT_W-1:0] PROT_RESET = 2'd2;

   // One page table entry; the valid bit lives in the group valid memory.
   typedef struct packed {
      logic [VSID_W-1:0] vsid;
      logic              hash_sel;
      logic [API_W-1:0]  api;
      logic [PFN_W-1:0]  rpn;
      logic              referenced;
      logic              changed;
      logic [PROT_W-1:0] prot;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic             full;
      logic [WAY_W-1:0] way;
   } victim_type;

   // First invalid way of a group, or the given fallback way when all are valid.
   function automatic victim_type pick_victim(input logic [WAYS-1:0] valid_bits,
                                              input logic [WAY_W-1:0] fallback);
      victim_type res;
      res.full = 1'b1;
      res.way = fallback;
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (!valid_bits[i]) begin
            res.full = 1'b0;
            res.way = WAY_W'(i);
         end
      end
      return res;
   endfunction

   function automatic entry_type pack_entry(input logic [VSID_W-1:0] vsid,
                                            input logic [API_W-1:0] api,
                                            input logic [PFN_W-1:0] rpn,
                                            input logic [PROT_W-1:0] prot);
      entry_type e;
      e.vsid = vsid;
      e.hash_sel = 1'b0;
      e.api = api;
      e.rpn = rpn;
      e.referenced = 1'b0;
      e.changed = 1'b0;
      e.prot = prot;
      return e;
   endfunction

endpackage

// File: rtl/core/hptr_channels.sv
// Request and response channel interfaces of the hashed page table refill block.
interface hptr_req_if;
   logic                          valid;
   logic                          ready;
   logic                          func;
   logic [hptr_pkg::VADDR_W-1:0]  virt_addr;
   logic [hptr_pkg::VSID_W-1:0]   vsid;
   logic [hptr_pkg::PFN_W-1:0]    frame_number;

   modport source (output valid, func, virt_addr, vsid, frame_number, input ready);
   modport sink (input valid, func, virt_addr, vsid, frame_number, output ready);
endinterface

interface hptr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [hptr_pkg::SLOT_W-1:0]   slot_index;
   logic                          group_was_full;
   logic                          done_res;

   modport source (output valid, slot_index, group_was_full, done_res, input ready);
   modport sink (input valid, slot_index, group_was_full, done_res, output ready);
endinterface

// File: rtl/core/hptr_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
module hptr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/hashed_page_table_refill_top.sv
// Top level of the hashed page table refill block: group valid memory, entry store, control.
// Refill: the group's valid bits are read on accept; once the result register is free, the
// entry is written and the result registered. No new item is taken until the valid memory
// read-then-write is done. Invalidate: a pass clearing every group of the valid memory, then
// a result. Reset (synchronous, active high) starts the same pass with no result;
// req_chan.ready stays low until it ends. Configuration writes are taken at any time.
module hashed_page_table_refill_top #(
   parameter int GROUPS = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   hptr_req_if.sink                    req_chan,
   hptr_rsp_if.source                  rsp_chan,
   input  logic                        csr_wr_en,
   input  logic [hptr_pkg::PROT_W-1:0] csr_wr_data
);

   // GROUPS must be a power of two, not enforced here; the group index is the hash's low bits.
   localparam int GROUP_BITS = $clog2(GROUPS);
   localparam int SLOT_FULL_W = GROUP_BITS + hptr_pkg::WAY_W;
   localparam int ENTRIES = GROUPS * hptr_pkg::WAYS;

   // Sequencer states.
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_LOOKUP = 2'd1;
   localparam logic [1:0] ST_CLEAR  = 2'd2;
   localparam logic [1:0] ST_RESP   = 2'd3;

   localparam logic FUNC_REFILL = 1'b0;

   logic [1:0]                    state_ff, state_in;
   logic [GROUP_BITS-1:0]         group_ff, group_in;
   logic [hptr_pkg::WAY_W-1:0]    page_lo_ff, page_lo_in;
   logic [hptr_pkg::VSID_W-1:0]   vsid_ff, vsid_in;
   logic [hptr_pkg::API_W-1:0]    api_ff, api_in;
   logic [hptr_pkg::PFN_W-1:0]    pfn_ff, pfn_in;
   logic [GROUP_BITS-1:0]         clr_cnt_ff, clr_cnt_in;
   logic                          clr_rsp_ff, clr_rsp_in;
   logic [hptr_pkg::PROT_W-1:0]   prot_ff, prot_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [hptr_pkg::SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic                          rsp_full_ff, rsp_full_in;

   logic                          accept;
   logic                          out_free;
   logic [hptr_pkg::PAGE_W-1:0]   req_page;
   logic [hptr_pkg::VSID_W-1:0]   req_hash;

   logic                          vmem_wr_en;
   logic [GROUP_BITS-1:0]         vmem_wr_addr;
   logic [hptr_pkg::WAYS-1:0]     vmem_wr_data;
   logic [GROUP_BITS-1:0]         vmem_rd_addr;
   logic [hptr_pkg::WAYS-1:0]     vmem_rd_data;

   logic                          emem_wr_en;
   logic [SLOT_FULL_W-1:0]        emem_addr;
   hptr_pkg::entry_type           emem_wr_data;

   hptr_pkg::victim_type          victim;

   // Page index and primary hash of the incoming address.
   assign req_page = req_chan.virt_addr[hptr_pkg::PAGE_SHIFT +: hptr_pkg::PAGE_W];
   assign req_hash = req_chan.vsid ^ hptr_pkg::VSID_W'(req_page);

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept = req_chan.valid && req_chan.ready;

   // The result register is free when it is empty or being taken this cycle.
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // The valid memory is read at the new group on an accept; otherwise it keeps
   // rereading the held group, so a stalled lookup still sees its data. A lookup
   // always writes back before the next item is accepted, so no forwarding is needed.
   assign vmem_rd_addr = accept ? req_hash[GROUP_BITS-1:0] : group_ff;

   assign victim = hptr_pkg::pick_victim(vmem_rd_data, page_lo_ff);
   assign emem_addr = {group_ff, victim.way};
   assign emem_wr_data = hptr_pkg::pack_entry(vsid_ff, api_ff, pfn_ff, prot_ff);

   always_comb begin
      state_in = state_ff;
      group_in = group_ff;
      page_lo_in = page_lo_ff;
      vsid_in = vsid_ff;
      api_in = api_ff;
      pfn_in = pfn_ff;
      clr_cnt_in = clr_cnt_ff;
      clr_rsp_in = clr_rsp_ff;
      prot_in = csr_wr_en ? csr_wr_data : prot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_slot_in = rsp_slot_ff;
      rsp_full_in = rsp_full_ff;
      vmem_wr_en = 1'b0;
      vmem_wr_addr = group_ff;
      vmem_wr_data = vmem_rd_data;
      emem_wr_en = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               group_in = req_hash[GROUP_BITS-1:0];
               page_lo_in = req_page[hptr_pkg::WAY_W-1:0];
               vsid_in = req_chan.vsid;
               api_in = req_chan.virt_addr[hptr_pkg::API_SHIFT +: hptr_pkg::API_W];
               pfn_in = req_chan.frame_number;
               if (req_chan.func == FUNC_REFILL) begin
                  state_in = ST_LOOKUP;
               end else begin
                  clr_cnt_in = '0;
                  clr_rsp_in = 1'b1;
                  state_in = ST_CLEAR;
               end
            end
         end
         ST_LOOKUP: begin
            // Valid bits of the group are on the memory output; hold until the
            // result register can take the result, then update both memories.
            if (out_free) begin
               vmem_wr_en = 1'b1;
               vmem_wr_addr = group_ff;
               vmem_wr_data = vmem_rd_data | (hptr_pkg::WAYS'(1) << victim.way);
               emem_wr_en = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_slot_in = hptr_pkg::SLOT_W'(emem_addr);
               rsp_full_in = victim.full;
               state_in = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            // One group of valid bits cleared per cycle; the count wraps to zero.
            vmem_wr_en = 1'b1;
            vmem_wr_addr = clr_cnt_ff;
            vmem_wr_data = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == {GROUP_BITS{1'b1}}) begin
               state_in = clr_rsp_ff ? ST_RESP : ST_IDLE;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in = '0;
               rsp_full_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_cnt_ff <= '0;
         clr_rsp_ff <= 1'b0;
         prot_ff <= hptr_pkg::PROT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         clr_rsp_ff <= clr_rsp_in;
         prot_ff <= prot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      group_ff <= group_in;
      page_lo_ff <= page_lo_in;
      vsid_ff <= vsid_in;
      api_ff <= api_in;
      pfn_ff <= pfn_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_full_ff <= rsp_full_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.slot_index = rsp_slot_ff;
   assign rsp_chan.group_was_full = rsp_full_ff;
   assign rsp_chan.done_res = 1'b1;

   // Per-group valid bits, one bit per way.
   hptr_ram #(
      .WIDTH (hptr_pkg::WAYS),
      .DEPTH (GROUPS)
   ) u_valid_ram (
      .clock   (clock),
      .wr_en   (vmem_wr_en),
      .wr_addr (vmem_wr_addr),
      .wr_data (vmem_wr_data),
      .rd_addr (vmem_rd_addr),
      .rd_data (vmem_rd_data)
   );

   // Entry contents; written by refills and not read back by this block.
   hptr_ram #(
      .WIDTH (hptr_pkg::ENTRY_W),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (emem_wr_en),
      .wr_addr (emem_addr),
      .wr_data (emem_wr_data),
      .rd_addr (emem_addr),
      .rd_data ()
   );

endmodule

// File: rtl/core/hptr_checker.sv
// Port-level assertions for the hashed page table refill block and their bind.
module hptr_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [hptr_pkg::SLOT_W-1:0] rsp_slot_index,
   input logic                        rsp_group_was_full,
   input logic                        rsp_done_res
);

   // A stalled result keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_slot_index)
                                  && $stable(rsp_group_was_full))
      else $error("stalled result changed or dropped");

   // Every result reports completion.
   a_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_done_res)
      else $error("result without done flag");

   // Only one item is worked on at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while another is in progress");

   // The clearing pass after reset keeps the input closed.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("input open or result shown right after reset");

endmodule

bind hashed_page_table_refill_top hptr_checker u_hptr_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_slot_index     (rsp_chan.slot_index),
   .rsp_group_was_full (rsp_chan.group_was_full),
   .rsp_done_res       (rsp_chan.done_res)
);
